// ===== design/rmf_pkg.sv =====
// rmf_pkg: shared types and constants for the running median filter.
// No dependencies.
package rmf_pkg;

    typedef logic [7:0] sample_t;

    // sort key: bit 8 set marks an empty cell, which sorts above every sample
    typedef logic [8:0] key_t;

    localparam sample_t SAMPLE_MAX = 8'hFF;
    localparam key_t    KEY_EMPTY  = 9'h100;
    localparam key_t    KEY_FLOOR  = 9'h000;

endpackage

// ===== design/running_median_filter.sv =====
// running_median_filter: sliding-window median over the last WINDOW_SIZE samples.
// Depends on rmf_pkg and rmf_cell.
//
// Usage:
//   Input channel in_valid/in_ready carries sample (16 bits, values above
//   255 saturate to 255). Output channel out_valid/out_ready carries median.
//   Exactly one median item per sample item, in order.
//   The window is a chain of WINDOW_SIZE sorted cells. On each accepted item
//   every cell updates at once from its neighbors: the oldest sample drops
//   out, the new one is slotted in by value.
//   The result is registered: out_valid rises in the cycle after acceptance.
//   Throughput: 1 item per cycle while out_ready is high; the single output register sets this.
//   While the window is filling, the result is the element at sorted index
//   floor(n/2) of the n samples seen so far.
//   Reset empties the window and clears out_valid; the median register itself is not reset.
//   When out_ready is low with a result held, in_ready drops; the held
//   result and the window stay unchanged until the result is taken.
module running_median_filter
    import rmf_pkg::*;
#(
    parameter int WINDOW_SIZE = 7
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] sample,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  median
);

    localparam int AGE_W = $clog2(WINDOW_SIZE);
    localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW_SIZE);

    logic                 accept;
    logic                 full;
    sample_t              s;
    logic [CNT_W-1:0]     fill_reg;
    logic [CNT_W-1:0]     fill_next;
    logic [CNT_W-1:0]     mid_idx;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    sample_t              median_reg;
    sample_t              median_next;

    key_t                 keys  [WINDOW_SIZE];
    logic [AGE_W-1:0]     ages  [WINDOW_SIZE];
    key_t                 rkeys [WINDOW_SIZE];
    logic [AGE_W-1:0]     rages [WINDOW_SIZE];
    key_t                 nkeys [WINDOW_SIZE];
    logic [WINDOW_SIZE:0] del_chain;
    logic [WINDOW_SIZE-1:0] empty_bits;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign full     = (fill_reg == FULL_CNT);
    assign s        = (|sample[15:8]) ? SAMPLE_MAX : sample[7:0];
    assign del_chain[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_SIZE; gi++)
        begin : g_cell
            key_t             up_key;
            logic [AGE_W-1:0] up_age;
            key_t             lo_rkey;
            logic [AGE_W-1:0] lo_rage;

            if (gi == WINDOW_SIZE - 1)
            begin : g_top
                assign up_key = KEY_EMPTY;
                assign up_age = '0;
            end
            else
            begin : g_mid
                assign up_key = keys[gi+1];
                assign up_age = ages[gi+1];
            end

            if (gi == 0)
            begin : g_bot
                assign lo_rkey = KEY_FLOOR;
                assign lo_rage = '0;
            end
            else
            begin : g_low
                assign lo_rkey = rkeys[gi-1];
                assign lo_rage = rages[gi-1];
            end

            rmf_cell #(
                .WINDOW_SIZE (WINDOW_SIZE),
                .AGE_W       (AGE_W)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .shift   (accept),
                .full    (full),
                .s       (s),
                .up_key  (up_key),
                .up_age  (up_age),
                .del_in  (del_chain[gi]),
                .lo_rkey (lo_rkey),
                .lo_rage (lo_rage),
                .key     (keys[gi]),
                .age     (ages[gi]),
                .del_out (del_chain[gi+1]),
                .rkey    (rkeys[gi]),
                .rage    (rages[gi]),
                .nkey    (nkeys[gi])
            );

            assign empty_bits[gi] = keys[gi][8];
        end
    endgenerate

    assign fill_next = full ? fill_reg : fill_reg + 1'b1;
    assign mid_idx   = fill_next >> 1;

    // pick the middle cell from the chain's next contents
    always_comb
    begin
        median_next = '0;
        for (int i = 0; i < WINDOW_SIZE; i++)
        begin
            if (mid_idx == CNT_W'(i))
            begin
                median_next = nkeys[i][7:0];
            end
        end
    end

    assign out_valid_next = accept || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                fill_reg <= fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            median_reg <= median_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign median    = median_reg;

    // sorted order of the two lowest cells
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        keys[0] <= keys[1])
        else $error("chain out of order");

    // occupied cells match the fill count
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(empty_bits) == WINDOW_SIZE - int'(fill_reg))
        else $error("cell occupancy differs from fill count");

    // fill count grows by one per item until full
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !full |=> fill_reg == $past(fill_reg) + 1'b1)
        else $error("fill count did not advance");

    // every accepted item yields a result next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("missing result");

    // a full window always has an oldest cell to drop; a window still filling has none
    a_evict: assert property (@(posedge clk) disable iff (!rst_n)
        del_chain[WINDOW_SIZE] == full)
        else $error("oldest sample not found");

endmodule

// ===== design/rmf_cell.sv =====
// rmf_cell: one cell of the sorted window chain; holds one sample and its age.
// Depends on rmf_pkg.
module rmf_cell
    import rmf_pkg::*;
#(
    parameter int WINDOW_SIZE = 7,
    parameter int AGE_W       = 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift,
    input  logic             full,
    input  sample_t          s,
    input  key_t             up_key,
    input  logic [AGE_W-1:0] up_age,
    input  logic             del_in,
    input  key_t             lo_rkey,
    input  logic [AGE_W-1:0] lo_rage,
    output key_t             key,
    output logic [AGE_W-1:0] age,
    output logic             del_out,
    output key_t             rkey,
    output logic [AGE_W-1:0] rage,
    output key_t             nkey
);

    localparam logic [AGE_W-1:0] OLD_AGE = AGE_W'(WINDOW_SIZE - 1);

    key_t             key_reg;
    key_t             key_next;
    logic [AGE_W-1:0] age_reg;
    logic [AGE_W-1:0] age_next;
    logic             is_old;
    logic             del_le;
    logic             gt;
    logic             lo_gt;
    key_t             s_key;

    assign s_key  = {1'b0, s};
    assign is_old = full && !key_reg[8] && (age_reg == OLD_AGE);
    assign del_le = del_in | is_old;

    // contents after the oldest sample is taken out of the chain
    assign rkey = del_le ? up_key : key_reg;
    assign rage = del_le ? up_age : age_reg;

    assign gt    = rkey > s_key;
    assign lo_gt = lo_rkey > s_key;

    always_comb
    begin
        priority if (gt && lo_gt)
        begin
            key_next = lo_rkey;
            age_next = lo_rage + 1'b1;
        end
        else if (gt)
        begin
            key_next = s_key;
            age_next = '0;
        end
        else
        begin
            key_next = rkey;
            age_next = rage + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= KEY_EMPTY;
            age_reg <= '0;
        end
        else if (shift)
        begin
            key_reg <= key_next;
            age_reg <= age_next;
        end
    end

    assign key     = key_reg;
    assign age     = age_reg;
    assign del_out = del_le;
    assign nkey    = key_next;

endmodule
